[hw/rtl/dpjq_pkg.sv]
// Package for the deadline priority job queue: item types, codes and controller/datapath links.
`default_nettype none

package dpjq_pkg;

    // Default queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int TAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int PRIO_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] MIN_RERUN_GAP_RST = 16'd61;
    localparam logic [CFG_DATA_W-1:0] LATE_GRACE_RST    = 16'd59;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RERUN_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATE_GRACE    = 2'd1;

    // Command codes
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_FLUSH  = 2'd2;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_DROPPED  = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_POPPED   = 3'd3;
    localparam t_status ST_NOT_DUE  = 3'd4;
    localparam t_status ST_EMPTY    = 3'd5;
    localparam t_status ST_FLUSHED  = 3'd6;

    // Input item
    typedef struct packed {
        t_cmd              cmd;
        logic [TAG_W-1:0]  job_tag;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] prior_run;
        logic [TIME_W-1:0] now_time;
        logic [PRIO_W-1:0] run_priority;
        logic [PRIO_W-1:0] job_priority;
    } t_in_item;

    // Result item
    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  out_tag;
        logic [TIME_W-1:0] out_time;
        logic [PRIO_W-1:0] out_priority;
        logic [CNT_W-1:0]  queue_count;
    } t_out_item;

    // One queue entry
    typedef struct packed {
        logic [TIME_W-1:0] ent_time;
        logic [PRIO_W-1:0] ent_prio;
        logic [TAG_W-1:0]  ent_tag;
    } t_entry;

    // Source of the job fields of a result
    typedef enum logic [1:0] {
        RES_HEAD,
        RES_POP,
        RES_ZERO
    } t_res_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     rd_top;
        logic     rd_one;
        logic     ins_move;
        logic     ins_place_above;
        logic     ins_place_zero;
        logic     pop_move;
        logic     fill_inc;
        logic     fill_dec;
        logic     fill_clear;
        logic     latch_pop;
        logic     res_load;
        t_res_sel res_sel;
        t_status  res_status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic drop;
        logic full;
        logic empty;
        logic due;
        logic fill_one;
        logic idx_zero;
        logic idx_last;
        logic greater;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/deadline_priority_job_queue.sv]
// Sequence: each item is captured and checked; an insert into a held queue then walks down from
//   the tail moving entries up, and a pop shifts the entries after the head down, before the result loads.
// Throughput: one item at a time, plus output stall; the next item is taken the cycle after the
//   result loads, and the insert and pop walks move one entry a cycle.
// Reset (synchronous, active low) empties the queue, drops any pending result and restores
//   min_rerun_gap to 61 and late_grace to 59; entry memory is not cleared.
`default_nettype none

module deadline_priority_job_queue #(
    parameter int QUEUE_DEPTH = dpjq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire dpjq_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output dpjq_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dpjq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dpjq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dpjq_pkg::t_dp_cmd  dp_cmd;
    dpjq_pkg::t_dp_stat dp_stat;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    dpjq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    dpjq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[hw/rtl/dpjq_dpath.sv]
// Datapath of the job queue: item register, entry memory, head copy, counters, result register.
`default_nettype none

module dpjq_dpath #(
    parameter int QUEUE_DEPTH = dpjq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dpjq_pkg::t_in_item                  i_in_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [dpjq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [dpjq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire dpjq_pkg::t_dp_cmd                   i_cmd,
    output dpjq_pkg::t_dp_stat                       o_stat,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output dpjq_pkg::t_out_item                      o_out_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = dpjq_pkg::TIME_W;

    // Configuration registers
    logic [dpjq_pkg::CFG_DATA_W-1:0] r_min_gap;
    logic [dpjq_pkg::CFG_DATA_W-1:0] r_grace;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= dpjq_pkg::MIN_RERUN_GAP_RST;
            r_grace   <= dpjq_pkg::LATE_GRACE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpjq_pkg::CFG_MIN_RERUN_GAP: r_min_gap <= i_cfg_data;
                dpjq_pkg::CFG_LATE_GRACE:    r_grace   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured item
    dpjq_pkg::t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    // New entry built from the item; run priority wins when set
    dpjq_pkg::t_entry new_ent;
    always_comb begin
        new_ent.ent_time = r_item.run_time;
        new_ent.ent_prio = (r_item.run_priority != '0) ? r_item.run_priority
                                                        : r_item.job_priority;
        new_ent.ent_tag  = r_item.job_tag;
    end

    // Fill count and scan index
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] top_idx;

    assign top_idx = AW'(r_fill - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.fill_clear) begin
                r_fill <= '0;
            end else if (i_cmd.fill_inc) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - CW'(1);
            end

            if (i_cmd.rd_top) begin
                r_idx <= top_idx;
            end else if (i_cmd.rd_one) begin
                r_idx <= AW'(1);
            end else if (i_cmd.ins_move) begin
                r_idx <= r_idx - AW'(1);
            end else if (i_cmd.pop_move) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Entry memory: one write and one registered read per cycle
    dpjq_pkg::t_entry r_mem [QUEUE_DEPTH];
    dpjq_pkg::t_entry r_rdata;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    dpjq_pkg::t_entry wr_data;

    always_comb begin
        if (i_cmd.rd_top) begin
            rd_addr = top_idx;
        end else if (i_cmd.rd_one) begin
            rd_addr = AW'(1);
        end else if (i_cmd.ins_move) begin
            rd_addr = r_idx - AW'(1);
        end else if (i_cmd.pop_move) begin
            rd_addr = r_idx + AW'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    always_comb begin
        wr_en   = i_cmd.ins_move | i_cmd.ins_place_above | i_cmd.ins_place_zero |
                  i_cmd.pop_move;
        wr_data = (i_cmd.ins_move | i_cmd.pop_move) ? r_rdata : new_ent;
        if (i_cmd.ins_place_zero) begin
            wr_addr = '0;
        end else if (i_cmd.pop_move) begin
            wr_addr = r_idx - AW'(1);
        end else begin
            wr_addr = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Copy of the head entry and of the job released by a pop
    dpjq_pkg::t_entry r_head;
    dpjq_pkg::t_entry r_pop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_place_zero) begin
            r_head <= new_ent;
        end else if (i_cmd.pop_move && r_idx == AW'(1)) begin
            r_head <= r_rdata;
        end
        if (i_cmd.latch_pop) begin
            r_pop <= r_head;
        end
    end

    // Drop tests in 33-bit arithmetic so nothing wraps
    logic [TW:0] gap_limit;
    logic [TW:0] late_limit;
    assign gap_limit  = {1'b0, r_item.prior_run} + (TW + 1)'(r_min_gap);
    assign late_limit = {1'b0, r_item.run_time} + (TW + 1)'(r_grace);

    // Status to the controller
    logic out_busy;
    assign out_busy = o_out_valid & i_out_stall;

    always_comb begin
        o_stat.cmd      = r_item.cmd;
        o_stat.drop     = ({1'b0, r_item.run_time} < gap_limit) ||
                          (late_limit < {1'b0, r_item.now_time});
        o_stat.full     = (r_fill >= CW'(QUEUE_DEPTH));
        o_stat.empty    = (r_fill == '0);
        o_stat.due      = (r_head.ent_time <= r_item.now_time);
        o_stat.fill_one = (r_fill == CW'(1));
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (r_idx == top_idx);
        o_stat.greater  = (r_rdata.ent_time > new_ent.ent_time) ||
                          ((r_rdata.ent_time == new_ent.ent_time) &&
                           (r_rdata.ent_prio > new_ent.ent_prio));
        o_stat.out_busy = out_busy;
    end

    // Result register
    dpjq_pkg::t_entry res_ent;
    always_comb begin
        case (i_cmd.res_sel)
            dpjq_pkg::RES_HEAD: res_ent = (r_fill != '0) ? r_head : '0;
            dpjq_pkg::RES_POP:  res_ent = r_pop;
            default:            res_ent = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_out_data.status       <= i_cmd.res_status;
            o_out_data.out_tag      <= res_ent.ent_tag;
            o_out_data.out_time     <= res_ent.ent_time;
            o_out_data.out_priority <= res_ent.ent_prio;
            o_out_data.queue_count  <= dpjq_pkg::CNT_W'(r_fill);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dpjq_ctrl.sv]
// Controller of the job queue: sequences check, insert scan, pop shift and result hand-off.
`default_nettype none

module dpjq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire dpjq_pkg::t_dp_stat i_stat,
    output dpjq_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INS_SCAN,
        S_INS_HEAD,
        S_POP_SHIFT,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    dpjq_pkg::t_status   r_status, n_status;
    dpjq_pkg::t_res_sel  r_sel, n_sel;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_sel    = r_sel;
        o_cmd    = '0;
        o_cmd.res_sel    = r_sel;
        o_cmd.res_status = r_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end

            S_CHECK: begin
                n_state = S_FINISH;
                case (i_stat.cmd)
                    dpjq_pkg::CMD_INSERT: begin
                        n_sel = dpjq_pkg::RES_HEAD;
                        if (i_stat.drop) begin
                            n_status = dpjq_pkg::ST_DROPPED;
                        end else if (i_stat.full) begin
                            n_status = dpjq_pkg::ST_FULL;
                        end else if (i_stat.empty) begin
                            n_status             = dpjq_pkg::ST_INSERTED;
                            o_cmd.ins_place_zero = 1'b1;
                            o_cmd.fill_inc       = 1'b1;
                        end else begin
                            n_status     = dpjq_pkg::ST_INSERTED;
                            o_cmd.rd_top = 1'b1;
                            n_state      = S_INS_SCAN;
                        end
                    end
                    dpjq_pkg::CMD_POP: begin
                        if (i_stat.empty) begin
                            n_status = dpjq_pkg::ST_EMPTY;
                            n_sel    = dpjq_pkg::RES_ZERO;
                        end else if (!i_stat.due) begin
                            n_status = dpjq_pkg::ST_NOT_DUE;
                            n_sel    = dpjq_pkg::RES_HEAD;
                        end else begin
                            n_status        = dpjq_pkg::ST_POPPED;
                            n_sel           = dpjq_pkg::RES_POP;
                            o_cmd.latch_pop = 1'b1;
                            if (i_stat.fill_one) begin
                                o_cmd.fill_dec = 1'b1;
                            end else begin
                                o_cmd.rd_one = 1'b1;
                                n_state      = S_POP_SHIFT;
                            end
                        end
                    end
                    dpjq_pkg::CMD_FLUSH: begin
                        n_status         = dpjq_pkg::ST_FLUSHED;
                        n_sel            = dpjq_pkg::RES_ZERO;
                        o_cmd.fill_clear = 1'b1;
                    end
                    default: begin
                        // unused command: no result
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Walk down from the tail, moving larger entries up one place
            S_INS_SCAN: begin
                if (i_stat.greater) begin
                    o_cmd.ins_move = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = S_INS_HEAD;
                    end
                end else begin
                    o_cmd.ins_place_above = 1'b1;
                    o_cmd.fill_inc        = 1'b1;
                    n_state               = S_FINISH;
                end
            end

            S_INS_HEAD: begin
                o_cmd.ins_place_zero = 1'b1;
                o_cmd.fill_inc       = 1'b1;
                n_state              = S_FINISH;
            end

            // Move every entry after the head down one place
            S_POP_SHIFT: begin
                o_cmd.pop_move = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.fill_dec = 1'b1;
                    n_state        = S_FINISH;
                end
            end

            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= dpjq_pkg::ST_INSERTED;
            r_sel    <= dpjq_pkg::RES_ZERO;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_sel    <= n_sel;
        end
    end

endmodule

`default_nettype wire

[tb/deadline_priority_job_queue_test.sv]
// Self-checking testbench for the deadline priority job queue: directed cases, then random commands.
module deadline_priority_job_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpjq_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam t_cmd CMD_UNUSED  = 2'd3;

    // Clock, reset and the block's ports
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Jobs waiting to be sent and results waiting to be seen
    t_in_item  pending_jobs[$];
    t_out_item expected_results[$];
    int        queued_count = 0;
    int        accepted_count = 0;
    int        error_count = 0;

    // Shadow of the queue contents and of the two registers
    t_entry          held_jobs[DEPTH];
    int              job_count = 0;
    logic [15:0]     rerun_gap = MIN_RERUN_GAP_RST;
    logic [15:0]     late_grace = LATE_GRACE_RST;

    // Stimulus pacing
    bit          idling_on = 1'b1;
    int          send_gap = 0;
    bit          drain_wait = 1'b0;
    int          stall_left = 0;
    logic [31:0] wall_clock = '0;

    deadline_priority_job_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Work out the result of one accepted job command and update the shadow queue
    task automatic predict_job_outcome(input t_in_item it);
        t_out_item         res;
        logic [PRIO_W-1:0] eff_prio;
        longint            span;
        longint            late_limit;
        int                slot;
        bit                show_head;
        res = '0;
        show_head = 1'b1;
        case (it.cmd)
            CMD_INSERT: begin
                eff_prio = (it.run_priority != '0) ? it.run_priority : it.job_priority;
                span = longint'({32'd0, it.run_time}) - longint'({32'd0, it.prior_run});
                late_limit = longint'({32'd0, it.run_time}) + longint'({48'd0, late_grace});
                if (span < longint'({48'd0, rerun_gap}) ||
                    late_limit < longint'({32'd0, it.now_time})) begin
                    res.status = ST_DROPPED;
                end else if (job_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // new job goes after everything with the same time and priority
                    slot = job_count;
                    for (int i = 0; i < job_count; i++) begin
                        if (held_jobs[i].ent_time > it.run_time ||
                            (held_jobs[i].ent_time == it.run_time &&
                             held_jobs[i].ent_prio > eff_prio)) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int i = job_count; i > slot; i--) begin
                        held_jobs[i] = held_jobs[i-1];
                    end
                    held_jobs[slot] = '{ent_time: it.run_time, ent_prio: eff_prio,
                                        ent_tag: it.job_tag};
                    job_count++;
                    res.status = ST_INSERTED;
                end
            end
            CMD_POP: begin
                show_head = 1'b0;
                if (job_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (held_jobs[0].ent_time > it.now_time) begin
                    res.status = ST_NOT_DUE;
                    show_head = 1'b1;
                end else begin
                    res.status = ST_POPPED;
                    res.out_tag = held_jobs[0].ent_tag;
                    res.out_time = held_jobs[0].ent_time;
                    res.out_priority = held_jobs[0].ent_prio;
                    for (int i = 1; i < job_count; i++) begin
                        held_jobs[i-1] = held_jobs[i];
                    end
                    job_count--;
                end
            end
            CMD_FLUSH: begin
                job_count = 0;
                res.status = ST_FLUSHED;
                show_head = 1'b0;
            end
            default: begin
                // unused command: no result, no change
                return;
            end
        endcase
        if (show_head && job_count > 0) begin
            res.out_tag = held_jobs[0].ent_tag;
            res.out_time = held_jobs[0].ent_time;
            res.out_priority = held_jobs[0].ent_prio;
        end
        res.queue_count = job_count[CNT_W-1:0];
        expected_results.push_back(res);
    endtask

    function automatic logic [31:0] clamp_time(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > longint'(32'hFFFF_FFFF)) begin
            return 32'hFFFF_FFFF;
        end
        return v[31:0];
    endfunction

    task automatic queue_job(input t_cmd c, input logic [15:0] tag, input logic [31:0] rt,
                             input logic [31:0] lr, input logic [31:0] now,
                             input logic [7:0] rp, input logic [7:0] jp);
        t_in_item it;
        it.cmd = c;
        it.job_tag = tag;
        it.run_time = rt;
        it.prior_run = lr;
        it.now_time = now;
        it.run_priority = rp;
        it.job_priority = jp;
        pending_jobs.push_back(it);
        queued_count++;
    endtask

    // Mostly well-formed inserts and pops around a moving wall clock, some near misses
    // and noise. Insert-heavy stretches fill the queue, pop-heavy ones drain it.
    task automatic queue_random_jobs(input int count);
        int          pick;
        int          insert_pct;
        longint      base;
        logic [31:0] rt;
        logic [31:0] lr;
        logic [31:0] now;
        logic [15:0] tag;
        logic [7:0]  rp;
        logic [7:0]  jp;
        insert_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) begin
                insert_pct = $urandom_range(0, 1) ? 70 : 35;
            end
            wall_clock = wall_clock + $urandom_range(0, 20);
            base = longint'({32'd0, wall_clock});
            tag = 16'($urandom);
            rp = ($urandom_range(0, 2) == 0) ? 8'd0 :
                 ($urandom_range(0, 1) ? 8'($urandom_range(1, 3)) : 8'($urandom));
            jp = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            now = wall_clock;
            pick = $urandom_range(0, 99);
            if (pick < insert_pct) begin
                // good insert, now and then slightly in the past
                if ($urandom_range(0, 3) == 0) begin
                    rt = clamp_time(base - longint'($urandom_range(0, late_grace)));
                end else begin
                    rt = clamp_time(base + longint'($urandom_range(0, 8) * 5));
                end
                lr = clamp_time(longint'({32'd0, rt}) - longint'({48'd0, rerun_gap})
                                - longint'($urandom_range(0, 100)));
                queue_job(CMD_INSERT, tag, rt, lr, now, rp, jp);
            end else if (pick < insert_pct + 6) begin
                // insert that misses one of the two windows by one second
                rt = clamp_time(base + longint'($urandom_range(0, 30)));
                if ($urandom_range(0, 1)) begin
                    lr = clamp_time(longint'({32'd0, rt}) - longint'({48'd0, rerun_gap}) + 1);
                end else begin
                    lr = clamp_time(longint'({32'd0, rt}) - longint'({48'd0, rerun_gap}) - 10);
                    now = clamp_time(longint'({32'd0, rt}) + longint'({48'd0, late_grace}) + 1);
                end
                queue_job(CMD_INSERT, tag, rt, lr, now, rp, jp);
            end else if (pick < insert_pct + 8) begin
                queue_job(CMD_FLUSH, tag, $urandom, $urandom, now, rp, jp);
            end else if (pick < insert_pct + 13) begin
                // anything at all, the unused command included
                queue_job(t_cmd'($urandom_range(0, 3)), tag, $urandom, $urandom, $urandom,
                          8'($urandom), 8'($urandom));
                if (pending_jobs[$].cmd == CMD_UNUSED) begin
                    n--;
                end
            end else begin
                now = clamp_time(base + longint'($urandom_range(0, 60)));
                queue_job(CMD_POP, tag, $urandom, $urandom, now, rp, jp);
            end
        end
    endtask

    // Wait until every job is sent and answered, then let the block go quiet
    task automatic settle_block();
        while (accepted_count != queued_count || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MIN_RERUN_GAP) begin
            rerun_gap = val;
        end else if (idx == CFG_LATE_GRACE) begin
            late_grace = val;
        end
    endtask

    // Driver: present pending jobs, predict each one as it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_job_outcome(in_item);
                accepted_count++;
                if (idling_on && (accepted_count % 64 == 0 || $urandom_range(0, 59) == 0)) begin
                    drain_wait = 1'b1;
                end else if (idling_on && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 4);
                end
            end
            if (drain_wait && expected_results.size() == 0) begin
                drain_wait = 1'b0;
            end
            if (!(in_valid && in_stall)) begin
                if (drain_wait || send_gap > 0 || pending_jobs.size() == 0) begin
                    if (send_gap > 0) begin
                        send_gap--;
                    end
                    in_valid <= 1'b0;
                end else begin
                    in_item <= pending_jobs.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: random stall bursts, each taken result checked against the oldest prediction
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("t=%0t: result %h with nothing expected", $time, out_item);
                end else begin
                    want = expected_results.pop_front();
                    if (want != out_item) begin
                        error_count++;
                        if (error_count <= 40) begin
                            if (want.status != out_item.status)
                                $display("t=%0t: status expected %0d, got %0d",
                                         $time, want.status, out_item.status);
                            if (want.out_tag != out_item.out_tag)
                                $display("t=%0t: out_tag expected %h, got %h",
                                         $time, want.out_tag, out_item.out_tag);
                            if (want.out_time != out_item.out_time)
                                $display("t=%0t: out_time expected %h, got %h",
                                         $time, want.out_time, out_item.out_time);
                            if (want.out_priority != out_item.out_priority)
                                $display("t=%0t: out_priority expected %0d, got %0d",
                                         $time, want.out_priority, out_item.out_priority);
                            if (want.queue_count != out_item.queue_count)
                                $display("t=%0t: queue_count expected %0d, got %0d",
                                         $time, want.queue_count, out_item.queue_count);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus phases
    initial begin
        logic [31:0] t0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: empty queue, window edges, extremes, fill and overfill
        t0 = 32'h0001_0000;
        queue_job(CMD_POP, 16'h0, '0, '0, t0, 8'd0, 8'd0);
        queue_job(CMD_FLUSH, 16'h0, '0, '0, t0, 8'd0, 8'd0);
        queue_job(CMD_UNUSED, 16'hFFFF, '1, '1, '1, 8'hFF, 8'hFF);
        queue_job(CMD_INSERT, 16'd1, t0 + 100, t0 + 40, t0, 8'd1, 8'd1);
        queue_job(CMD_INSERT, 16'd2, t0 + 100, t0 + 39, t0 + 159, 8'd0, 8'd7);
        queue_job(CMD_INSERT, 16'd3, t0 + 100, '0, t0 + 160, 8'd2, 8'd0);
        queue_job(CMD_INSERT, 16'd4, t0 + 100, t0 + 200, t0, 8'd2, 8'd0);
        queue_job(CMD_INSERT, 16'd5, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 8'hFF, 8'd0);
        queue_job(CMD_INSERT, 16'd6, '0, '0, '0, 8'd3, 8'd3);
        for (int i = 0; i < DEPTH - 2; i++) begin
            queue_job(CMD_INSERT, (i == DEPTH - 3) ? 16'hFFFF : 16'h100 + 16'(i),
                      t0 + 90 + 32'(10 * (i % 3)), '0, t0,
                      (i % 2 != 0) ? 8'(i % 4) : 8'd0, 8'(7 - i % 5));
        end
        queue_job(CMD_INSERT, 16'hBEEF, t0 + 50, '0, t0, 8'd1, 8'd1);
        queue_job(CMD_INSERT, 16'hDEAD, t0 + 50, t0 + 50, t0, 8'd1, 8'd1);
        queue_job(CMD_POP, 16'h0, '0, '0, t0 + 89, 8'd0, 8'd0);
        queue_job(CMD_POP, 16'h0, '0, '0, t0 + 90, 8'd0, 8'd0);
        queue_job(CMD_POP, 16'h0, '0, '0, 32'hFFFF_FFFF, 8'd0, 8'd0);
        queue_job(CMD_FLUSH, 16'h0, '0, '0, t0, 8'd0, 8'd0);
        wall_clock = t0;
        queue_random_jobs(220);
        settle_block();

        // Both windows closed to zero
        write_reg(CFG_MIN_RERUN_GAP, 16'd0);
        write_reg(CFG_LATE_GRACE, 16'd0);
        queue_job(CMD_INSERT, 16'd7, '0, '0, '0, 8'd0, 8'd0);
        queue_job(CMD_INSERT, 16'd8, 32'd5, 32'd5, 32'd6, 8'd4, 8'd0);
        queue_job(CMD_INSERT, 16'd9, 32'd5, 32'd5, 32'd5, 8'd4, 8'd0);
        wall_clock = $urandom;
        queue_random_jobs(180);
        settle_block();

        // Both windows wide open
        write_reg(CFG_MIN_RERUN_GAP, 16'hFFFF);
        write_reg(CFG_LATE_GRACE, 16'hFFFF);
        t0 = 32'h8000_0000;
        queue_job(CMD_INSERT, 16'd10, t0, t0 - 32'd65535, t0, 8'd9, 8'd0);
        queue_job(CMD_INSERT, 16'd11, t0, t0 - 32'd65534, t0, 8'd9, 8'd0);
        wall_clock = $urandom;
        queue_random_jobs(180);
        settle_block();

        // Random settings near the top of the time range
        write_reg(CFG_MIN_RERUN_GAP, 16'($urandom));
        write_reg(CFG_LATE_GRACE, 16'($urandom));
        wall_clock = 32'hFFFF_F000;
        queue_random_jobs(160);
        settle_block();

        // Back to small windows, full rate on both sides
        idling_on = 1'b0;
        write_reg(CFG_MIN_RERUN_GAP, 16'($urandom_range(0, 200)));
        write_reg(CFG_LATE_GRACE, 16'($urandom_range(0, 200)));
        wall_clock = $urandom;
        queue_random_jobs(150);
        settle_block();

        if (error_count == 0) begin
            $display("[deadline_priority_job_queue] OK");
        end else begin
            $display("[deadline_priority_job_queue] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("t=%0t: timeout, %0d results still expected", $time, expected_results.size());
        $display("[deadline_priority_job_queue] ERROR");
        $finish;
    end

endmodule
